>>> rtl/psd_pkg.sv
// ----------------------------------------------------------------------------
// psd_pkg
// Shared types and constants for the H.264 parameter set detector.
// ----------------------------------------------------------------------------
package psd_pkg;

   localparam logic [4:0] TYPE_MASK = 5'h1F;
   localparam logic [4:0] TYPE_SPS  = 5'd7;
   localparam logic [4:0] TYPE_PPS  = 5'd8;
   localparam logic [7:0] BYTE_ZERO = 8'h00;
   localparam logic [7:0] BYTE_ONE  = 8'h01;
   localparam logic [1:0] LEN_LAST  = 2'd3;   // index of final length byte

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic has_sps;
      logic has_pps;
      logic annex_b_format;
   } rsp_type;

   // Classified byte as it sits in the queue
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
      logic       is_zero;
      logic       is_one;
      logic       is_sps;
      logic       is_pps;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

>>> rtl/psd_front.sv
// ----------------------------------------------------------------------------
// psd_front
// Accepts request bytes and classifies them for the parsers.
// ----------------------------------------------------------------------------
module psd_front (
   input  logic                 req_valid,
   output logic                 req_stall,
   input  psd_pkg::req_type     req_payload,
   input  psd_pkg::qstat_type   q_stat,
   output logic                 push,
   output psd_pkg::entry_type   push_entry
);

   logic [4:0] nal_type;

   assign nal_type  = req_payload.data_byte[4:0] & psd_pkg::TYPE_MASK;
   assign req_stall = q_stat.full;
   assign push      = req_valid && !q_stat.full;

   always_comb begin
      push_entry.data_byte = req_payload.data_byte;
      push_entry.last_byte = req_payload.last_byte;
      push_entry.is_zero   = (req_payload.data_byte == psd_pkg::BYTE_ZERO);
      push_entry.is_one    = (req_payload.data_byte == psd_pkg::BYTE_ONE);
      push_entry.is_sps    = (nal_type == psd_pkg::TYPE_SPS);
      push_entry.is_pps    = (nal_type == psd_pkg::TYPE_PPS);
   end

endmodule

>>> rtl/psd_queue.sv
// ----------------------------------------------------------------------------
// psd_queue
// Small register queue between the front and back parts.
// ----------------------------------------------------------------------------
module psd_queue #(
   parameter int DEPTH = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  psd_pkg::entry_type   push_entry,
   input  logic                 pop,
   output psd_pkg::entry_type   head,
   output psd_pkg::qstat_type   q_stat
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] PTR_MAX = PW'(DEPTH - 1);
   localparam logic [CW-1:0] CNT_MAX = CW'(DEPTH);

   psd_pkg::entry_type mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_MAX) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_MAX) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head         = mem_ff[rd_ptr_ff];
   assign q_stat.full  = (count_ff == CNT_MAX);
   assign q_stat.empty = (count_ff == '0);

endmodule

>>> rtl/psd_back.sv
// ----------------------------------------------------------------------------
// psd_back
// Annex-B and length-prefixed parsers plus the result register.
// ----------------------------------------------------------------------------
module psd_back (
   input  logic                 clock,
   input  logic                 reset,
   input  psd_pkg::entry_type   head,
   input  psd_pkg::qstat_type   q_stat,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output psd_pkg::rsp_type     rsp_payload
);

   // Annex-B scanner
   logic z0_ff, z0_in;          // previous byte was zero
   logic z1_ff, z1_in;          // byte before that was zero
   logic hdr_ff, hdr_in;        // next byte is a NAL header
   logic seen_ff, seen_in;
   logic a_sps_ff, a_sps_in;
   logic a_pps_ff, a_pps_in;

   // Length-prefixed scanner
   logic [1:0]  idx_ff, idx_in;
   logic        body_ff, body_in;
   logic        first_ff, first_in;   // next body byte is the NAL header
   logic [31:0] acc_ff, acc_in;
   logic [31:0] rem_ff, rem_in;
   logic        stop_ff, stop_in;
   logic        p_sps_ff, p_sps_in;   // pending body type is SPS
   logic        p_pps_ff, p_pps_in;
   logic        l_sps_ff, l_sps_in;
   logic        l_pps_ff, l_pps_in;

   logic [31:0] rem_dec;
   logic        out_free;

   psd_pkg::rsp_type rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // only a last byte needs the response register
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign pop      = !q_stat.empty && (out_free || !head.last_byte);
   assign rem_dec  = rem_ff - 32'd1;

   always_comb begin
      z0_in = z0_ff;  z1_in = z1_ff;  hdr_in = hdr_ff;  seen_in = seen_ff;
      a_sps_in = a_sps_ff;  a_pps_in = a_pps_ff;
      idx_in = idx_ff;  body_in = body_ff;  first_in = first_ff;
      acc_in = acc_ff;  rem_in = rem_ff;  stop_in = stop_ff;
      p_sps_in = p_sps_ff;  p_pps_in = p_pps_ff;
      l_sps_in = l_sps_ff;  l_pps_in = l_pps_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (pop) begin
         // Annex-B
         if (hdr_ff) begin
            if (head.is_sps) a_sps_in = 1'b1;
            if (head.is_pps) a_pps_in = 1'b1;
            hdr_in = 1'b0;
         end
         if (head.is_one && z0_ff && z1_ff) begin
            seen_in = 1'b1;
            hdr_in  = 1'b1;
         end
         z1_in = z0_ff;
         z0_in = head.is_zero;

         // Length-prefixed
         if (!stop_ff) begin
            if (!body_ff) begin
               acc_in = {acc_ff[23:0], head.data_byte};
               idx_in = idx_ff + 2'd1;
               if (idx_ff == psd_pkg::LEN_LAST) begin
                  if (acc_in == '0) begin
                     stop_in = 1'b1;
                  end else begin
                     body_in  = 1'b1;
                     first_in = 1'b1;
                     rem_in   = acc_in;
                  end
               end
            end else begin
               if (first_ff) begin
                  p_sps_in = head.is_sps;
                  p_pps_in = head.is_pps;
                  first_in = 1'b0;
               end
               rem_in = rem_dec;
               if (rem_dec == '0) begin
                  if (p_sps_in) l_sps_in = 1'b1;
                  if (p_pps_in) l_pps_in = 1'b1;
                  body_in = 1'b0;
                  acc_in  = '0;
               end
            end
         end

         if (head.last_byte) begin
            rsp_valid_in          = 1'b1;
            rsp_in.annex_b_format = seen_in;
            rsp_in.has_sps        = seen_in ? a_sps_in : l_sps_in;
            rsp_in.has_pps        = seen_in ? a_pps_in : l_pps_in;
            // unit done: back to idle
            z0_in = 1'b0;  z1_in = 1'b0;  hdr_in = 1'b0;  seen_in = 1'b0;
            a_sps_in = 1'b0;  a_pps_in = 1'b0;
            idx_in = '0;  body_in = 1'b0;  first_in = 1'b0;
            acc_in = '0;  rem_in = '0;  stop_in = 1'b0;
            p_sps_in = 1'b0;  p_pps_in = 1'b0;
            l_sps_in = 1'b0;  l_pps_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         z0_ff <= 1'b0;  z1_ff <= 1'b0;  hdr_ff <= 1'b0;  seen_ff <= 1'b0;
         a_sps_ff <= 1'b0;  a_pps_ff <= 1'b0;
         idx_ff <= '0;  body_ff <= 1'b0;  first_ff <= 1'b0;
         acc_ff <= '0;  rem_ff <= '0;  stop_ff <= 1'b0;
         p_sps_ff <= 1'b0;  p_pps_ff <= 1'b0;
         l_sps_ff <= 1'b0;  l_pps_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         z0_ff <= z0_in;  z1_ff <= z1_in;  hdr_ff <= hdr_in;  seen_ff <= seen_in;
         a_sps_ff <= a_sps_in;  a_pps_ff <= a_pps_in;
         idx_ff <= idx_in;  body_ff <= body_in;  first_ff <= first_in;
         acc_ff <= acc_in;  rem_ff <= rem_in;  stop_ff <= stop_in;
         p_sps_ff <= p_sps_in;  p_pps_ff <= p_pps_in;
         l_sps_ff <= l_sps_in;  l_pps_ff <= l_pps_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

>>> rtl/h264_parameter_set_detector.sv
// ----------------------------------------------------------------------------
// h264_parameter_set_detector
// Reports whether an H.264 access unit carries an SPS and a PPS.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel: one byte of the access unit per request, last_byte set on
//    the final byte. Units are sent back to back; an empty unit is not sent.
//  - rsp channel: one response per unit, after its last byte. annex_b_format
//    says whether start codes were found; has_sps/has_pps come from the
//    start-code scanner in that case, otherwise from the 4-byte length scan.
//  - Throughput: one byte per cycle while req_stall is low, set by the
//    single-byte step of both scanners in the back part.
//  - The last byte is registered in the queue, then popped into the response
//    register behind rsp_valid; bytes waiting ahead of it in the queue delay it.
//  - rsp_stall holds the response register; only the next unit's last byte
//    waits on it, earlier bytes keep flowing. The queue (QUEUE_DEPTH entries)
//    then fills behind that last byte, and once full req_stall rises.
//  - Reset (synchronous) empties the queue, clears both scanners and drops
//    rsp_valid; req_stall is low right after reset.
// ----------------------------------------------------------------------------
module h264_parameter_set_detector #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  psd_pkg::req_type   req_payload,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output psd_pkg::rsp_type   rsp_payload
);

   psd_pkg::qstat_type q_stat;
   psd_pkg::entry_type push_entry;
   psd_pkg::entry_type head;
   logic               push;
   logic               pop;

   // Front: accept and classify bytes
   psd_front u_front (
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .q_stat      (q_stat),
      .push        (push),
      .push_entry  (push_entry)
   );

   // Decoupling queue
   psd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .q_stat     (q_stat)
   );

   // Back: both scanners and the response register
   psd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .q_stat      (q_stat),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

>>> rtl/psd_checker.sv
// ----------------------------------------------------------------------------
// psd_checker
// Port-level checks for the parameter set detector.
// ----------------------------------------------------------------------------
module psd_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input psd_pkg::req_type   req_payload,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input psd_pkg::rsp_type   rsp_payload
);

   // Held response stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("response changed while stalled");

   // Out of reset: nothing pending, ready for requests
   a_reset_idle: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid && !req_stall)
      else $error("not idle after reset");

   // Queue only fills through accepted requests
   a_stall_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(req_valid && !req_stall))
      else $error("stall rose without an accepted request");

   // A new response cannot rise straight out of reset
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(reset))
      else $error("response right after reset");

endmodule

bind h264_parameter_set_detector psd_checker u_psd_checker (.*);
